### design/ascii85_stream_encoder_macros.svh
// Assertion macros used by the ascii85 encoder checker.
`ifndef ASCII85_STREAM_ENCODER_MACROS_SVH
`define ASCII85_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication.
`define A85_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define A85_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/a85_pkg.sv
// Types and constants of the ascii85 stream encoder.
package a85_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int DIGIT_W    = 7;

  localparam logic [6:0]  LINE_LIMIT  = 7'd75;
  localparam logic [7:0]  OFFSET      = 8'd33;
  localparam logic [7:0]  DIGIT_MAX   = 8'd117;
  // floor(v / 85) == (v * RECIP) >> RECIP_SHIFT for any 32-bit v
  localparam logic [31:0] RECIP       = 32'd3233857729;
  localparam int          RECIP_SHIFT = 38;

  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } a85_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_output;
  } a85_out_t;

  // One unit of work for the back end.
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  ndig;
    logic        zero;
    logic        crlf;
    logic        term;
  } a85_job_t;

  // Job plus its digits, most significant in entry 0.
  typedef struct packed {
    a85_job_t                                job;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]      digits;
  } a85_grp_t;

endpackage

### design/ascii85_stream_encoder.sv
// Top level of the ascii85 stream encoder.
//
//   channel   handshake          payload                       direction
//   input     push / full        in_item  (data_byte, end)     into block
//   output    empty / pop        out_item (out_char, end)      out of block
//
// A byte is taken in every cycle while the job queue has room.
// Each group takes a setup multiply and, if not all zero, five divide-by-85
// converter steps, overlapped with emission of the previous group.
// Unless stalled, output runs one character per cycle, up to 7 per group
// plus "~>" at the end; output channel and converter set the sustained rate.
// rst is synchronous and clears queue, converter, sequencer and output.
// Either side may stall freely; stalls back up through the job queue.
module ascii85_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  a85_pkg::a85_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output a85_pkg::a85_out_t out_item
);

  a85_pkg::a85_job_t job;
  a85_pkg::a85_job_t q_head;
  a85_pkg::a85_grp_t grp;
  logic              job_push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              grp_ready;
  logic              grp_take;
  logic              accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  a85_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .accept   (accept),
    .job      (job),
    .job_push (job_push)
  );

  a85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  a85_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .job_empty (q_empty),
    .job       (q_head),
    .job_pop   (q_pop),
    .grp       (grp),
    .grp_ready (grp_ready),
    .grp_take  (grp_take)
  );

  a85_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_ready (grp_ready),
    .grp_take  (grp_take),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### design/a85_front.sv
// Byte gathering, group classification and line counting.
module a85_front (
  input  logic              clk,
  input  logic              rst,
  input  a85_pkg::a85_in_t  in_item,
  input  logic              accept,
  output a85_pkg::a85_job_t job,
  output logic              job_push
);

  logic [31:0] gval;
  logic [1:0]  fill;
  logic [6:0]  line;

  logic [31:0] placed;
  logic [31:0] nv;
  logic        grp_full;
  logic        zero;
  logic [6:0]  lc;
  logic        brk;
  logic        last;

  always_comb begin
    case (fill)
      2'd0:    placed = {in_item.data_byte, 24'd0};
      2'd1:    placed = {8'd0, in_item.data_byte, 16'd0};
      2'd2:    placed = {16'd0, in_item.data_byte, 8'd0};
      default: placed = {24'd0, in_item.data_byte};
    endcase
  end

  assign last     = in_item.end_of_input;
  assign nv       = gval | placed;
  assign grp_full = (fill == 2'd3);
  assign zero     = (nv == 32'd0);
  assign lc       = line + (zero ? 7'd1 : 7'd5);
  assign brk      = (lc >= a85_pkg::LINE_LIMIT);

  always_comb begin
    job.value = nv;
    job.zero  = grp_full && zero;
    job.crlf  = grp_full && brk;
    job.term  = last;
    if (grp_full) begin
      job.ndig = zero ? 3'd0 : 3'd5;
    end else if (last) begin
      job.ndig = {1'b0, fill} + 3'd2;
    end else begin
      job.ndig = 3'd0;
    end
  end

  assign job_push = accept && (grp_full || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      gval <= '0;
      fill <= '0;
      line <= '0;
    end else if (accept) begin
      if (grp_full || last) begin
        gval <= '0;
        fill <= '0;
      end else begin
        gval <= nv;
        fill <= fill + 2'd1;
      end
      if (last) begin
        line <= '0;
      end else if (grp_full) begin
        line <= brk ? 7'd0 : lc;
      end
    end
  end

endmodule

### design/a85_queue.sv
// Short job queue between front and back end.
module a85_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  a85_pkg::a85_job_t wdata,
  output logic              full,
  input  logic              pop,
  output a85_pkg::a85_job_t rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  a85_pkg::a85_job_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/a85_conv.sv
// Base-85 digit converter: one reciprocal multiply per digit.
module a85_conv (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  a85_pkg::a85_job_t job,
  output logic              job_pop,
  output a85_pkg::a85_grp_t grp,
  output logic              grp_ready,
  input  logic              grp_take
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] LAST_STEP = 3'd4;
  localparam int         Q_W       = 64 - a85_pkg::RECIP_SHIFT;

  logic [1:0]  state;
  logic [2:0]  cnt;
  logic [31:0] cur;
  logic [63:0] prod;
  a85_pkg::a85_job_t jobr;
  logic [a85_pkg::NUM_DIGITS-1:0][a85_pkg::DIGIT_W-1:0] digs;

  logic [Q_W-1:0] q;
  logic [31:0]    q_ext;
  logic [31:0]    q85;
  logic [31:0]    rem;
  logic [31:0]    mul_a;
  logic [63:0]    prod_next;
  logic           can_load;

  assign q     = prod[63:a85_pkg::RECIP_SHIFT];
  assign q_ext = 32'(q);
  assign q85   = (q_ext << 6) + (q_ext << 4) + (q_ext << 2) + q_ext;
  assign rem   = cur - q85;

  assign can_load  = (state == ST_IDLE) || ((state == ST_DONE) && grp_take);
  assign job_pop   = can_load && !job_empty;
  assign mul_a     = job_pop ? job.value : q_ext;
  assign prod_next = 64'(mul_a) * 64'(a85_pkg::RECIP);

  assign grp_ready  = (state == ST_DONE);
  assign grp.job    = jobr;
  assign grp.digits = digs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else if (job_pop) begin
      cnt   <= '0;
      state <= (job.ndig == 3'd0) ? ST_DONE : ST_CONV;
    end else begin
      case (state)
        ST_CONV: begin
          cnt <= cnt + 3'd1;
          if (cnt == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (grp_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      jobr <= job;
      cur  <= job.value;
      prod <= prod_next;
    end else if (state == ST_CONV) begin
      digs[LAST_STEP - cnt] <= rem[a85_pkg::DIGIT_W-1:0];
      cur  <= q_ext;
      prod <= prod_next;
    end
  end

endmodule

### design/a85_emit.sv
// Character sequencer with output register.
module a85_emit (
  input  logic              clk,
  input  logic              rst,
  input  a85_pkg::a85_grp_t grp,
  input  logic              grp_ready,
  output logic              grp_take,
  output a85_pkg::a85_out_t out_item,
  output logic              empty,
  input  logic              pop
);

  localparam logic [3:0] SLOT_Z     = 4'd0;
  localparam logic [3:0] SLOT_D0    = 4'd1;
  localparam logic [3:0] SLOT_D1    = 4'd2;
  localparam logic [3:0] SLOT_D2    = 4'd3;
  localparam logic [3:0] SLOT_D3    = 4'd4;
  localparam logic [3:0] SLOT_D4    = 4'd5;
  localparam logic [3:0] SLOT_CR    = 4'd6;
  localparam logic [3:0] SLOT_LF    = 4'd7;
  localparam logic [3:0] SLOT_TILDE = 4'd8;
  localparam logic [3:0] SLOT_GT    = 4'd9;
  localparam int         NSLOT      = 10;

  logic [NSLOT-1:0]  mask;
  a85_pkg::a85_grp_t gr;
  logic              ovalid;
  a85_pkg::a85_out_t oitem;

  logic [3:0]        sel;
  logic              advance;
  logic [NSLOT-1:0]  mask_left;
  logic [NSLOT-1:0]  new_mask;
  logic [4:0]        dig_en;
  logic [7:0]        ch;

  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 4'(i);
      end
    end
  end

  assign advance   = (mask != '0) && (!ovalid || pop);
  assign mask_left = advance ? (mask & ~(NSLOT'(1) << sel)) : mask;
  assign grp_take  = grp_ready && (mask_left == '0);

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      dig_en[i] = (3'(i) < grp.job.ndig);
    end
  end

  assign new_mask = {grp.job.term, grp.job.term, grp.job.crlf, grp.job.crlf,
                     dig_en, grp.job.zero};

  always_comb begin
    case (sel)
      SLOT_Z:     ch = a85_pkg::CH_Z;
      SLOT_D0:    ch = {1'b0, gr.digits[0]} + a85_pkg::OFFSET;
      SLOT_D1:    ch = {1'b0, gr.digits[1]} + a85_pkg::OFFSET;
      SLOT_D2:    ch = {1'b0, gr.digits[2]} + a85_pkg::OFFSET;
      SLOT_D3:    ch = {1'b0, gr.digits[3]} + a85_pkg::OFFSET;
      SLOT_D4:    ch = {1'b0, gr.digits[4]} + a85_pkg::OFFSET;
      SLOT_CR:    ch = a85_pkg::CH_CR;
      SLOT_LF:    ch = a85_pkg::CH_LF;
      SLOT_TILDE: ch = a85_pkg::CH_TILDE;
      SLOT_GT:    ch = a85_pkg::CH_GT;
      default:    ch = a85_pkg::CH_GT;
    endcase
  end

  assign out_item = oitem;
  assign empty    = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask   <= '0;
      ovalid <= 1'b0;
    end else begin
      mask <= grp_take ? new_mask : mask_left;
      if (advance) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oitem.out_char      <= ch;
      oitem.end_of_output <= (sel == SLOT_GT);
    end
    if (grp_take) begin
      gr <= grp;
    end
  end

endmodule

### design/a85_checker.sv
// Port-level checks of the ascii85 stream encoder, bound to the top level.
`include "ascii85_stream_encoder_macros.svh"

module a85_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input a85_pkg::a85_out_t out_item
);

  `A85_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, empty && !full, "not idle after reset")

  `A85_ASSERT_NEXT(a_out_hold, clk, rst, !empty && !pop, !empty && $stable(out_item), "output changed while stalled")

  `A85_ASSERT_NOW(a_end_is_gt, clk, rst, !empty && out_item.end_of_output, out_item.out_char == a85_pkg::CH_GT, "end flag on a character other than '>'")

  `A85_ASSERT_NOW(a_legal_char, clk, rst, !empty, (out_item.out_char >= a85_pkg::OFFSET && out_item.out_char <= a85_pkg::DIGIT_MAX) || out_item.out_char == a85_pkg::CH_Z || out_item.out_char == a85_pkg::CH_CR || out_item.out_char == a85_pkg::CH_LF || out_item.out_char == a85_pkg::CH_TILDE, "character outside the encoding alphabet")

endmodule

bind ascii85_stream_encoder a85_checker u_a85_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
